FILE: hdl/usm_pkg.sv
package usm_pkg;

    // geometry
    localparam int MAX_WIDTH   = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WEFF_W      = COL_W + 1;
    localparam int FW_W        = 13;
    localparam int FH_W        = 16;
    localparam int PIX_W       = 8;
    localparam int STORED_ROWS = 4;
    localparam int WIN_N       = STORED_ROWS + 1;
    localparam int LB_W        = STORED_ROWS * PIX_W;
    localparam int LANE_W      = $clog2(STORED_ROWS);
    localparam int LEAD_W      = $clog2(2 * MAX_WIDTH + 3);

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

    // kernel: centre tap and magnitudes of the negative taps
    localparam int TAP_CENTRE = 505;
    localparam int TAP_A      = 1;
    localparam int TAP_B      = 4;
    localparam int TAP_C      = 7;
    localparam int TAP_D      = 16;
    localparam int TAP_E      = 26;
    localparam int KERNEL_SUM = 273;
    localparam int SUM_W      = 19;
    localparam int SAT_LIMIT  = KERNEL_SUM * 256;

    // divide by KERNEL_SUM as multiply by rounded-up reciprocal
    localparam int QX_W        = 17;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP       = (2 ** RECIP_SHIFT + KERNEL_SUM - 1) / KERNEL_SUM;
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = QX_W + RECIP_W;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t pixel_out;
        logic frame_last;
    } res_t;

endpackage

FILE: hdl/usm_pix_in_if.sv
interface usm_pix_in_if;
    logic                 valid;
    logic                 ready;
    usm_pkg::pix_t        pixel_in;
    logic                 drain;

    modport source (output valid, output pixel_in, output drain, input ready);
    modport sink (input valid, input pixel_in, input drain, output ready);
endinterface

FILE: hdl/usm_pix_out_if.sv
interface usm_pix_out_if;
    logic                 valid;
    logic                 ready;
    usm_pkg::pix_t        pixel_out;
    logic                 frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

FILE: hdl/usm_cfg_if.sv
interface usm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [usm_pkg::CFG_IDX_W-1:0]      index;
    logic [usm_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/unsharp_mask_5x5_filter.sv
// A result is registered through stages 1 to 5 and the result queue before it leaves.
// Throughput: one beat per cycle, pixel or drain, while the queue has room; the line store takes
// one read and one write per cycle, and a 8-entry result queue keeps input flowing under stall.
// Reset: counters, occupancy and queue clear, frame_width=640, frame_height=480.
// The line store and the window are not cleared; entries of rows not yet written are masked.
module unsharp_mask_5x5_filter (
    input  logic          clk,
    input  logic          rst_n,
    usm_pix_in_if.sink    pix_in,
    usm_pix_out_if.source pix_out,
    usm_cfg_if.sink       cfg
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [usm_pkg::FW_W-1:0]   fw_reg;
    logic [usm_pkg::FH_W-1:0]   fh_reg;
    logic                       cfg_acc;
    logic                       cfg_hit;
    logic [usm_pkg::WEFF_W-1:0] w_eff;
    logic [usm_pkg::FH_W-1:0]   h_eff;

    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid && cfg.ready;
    // a write to an unknown index does nothing, including no frame restart
    assign cfg_hit   = cfg_acc && ((cfg.index == usm_pkg::REG_FRAME_WIDTH) ||
                                   (cfg.index == usm_pkg::REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= usm_pkg::FW_RESET;
            fh_reg <= usm_pkg::FH_RESET;
        end
        else if (cfg_acc)
        begin
            case (cfg.index)
                usm_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg.data[usm_pkg::FW_W-1:0];
                usm_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg.data[usm_pkg::FH_W-1:0];
                default:                   fw_reg <= fw_reg;
            endcase
        end
    end

    // effective geometry: width clamped to 1..MAX_WIDTH, height at least 1
    always_comb
    begin
        if (fw_reg == '0)
            w_eff = usm_pkg::WEFF_W'(1);
        else if (32'(fw_reg) > usm_pkg::MAX_WIDTH)
            w_eff = usm_pkg::WEFF_W'(usm_pkg::MAX_WIDTH);
        else
            w_eff = usm_pkg::WEFF_W'(fw_reg);
        h_eff = (fh_reg == '0) ? usm_pkg::FH_W'(1) : fh_reg;
    end

    // ------------------------------------------------------------------
    // Stage 0: raster counters, beat decode, line store read
    // ------------------------------------------------------------------
    // in_col/in_row: position of the next input pixel.
    // out_col/out_row: position of the next result in the frame.
    // lead: pixels seen so far, saturating at 2W+2 (first result).
    logic [usm_pkg::COL_W-1:0]  in_col_reg, in_col_next;
    logic [usm_pkg::FH_W-1:0]   in_row_reg, in_row_next;
    logic [usm_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [usm_pkg::FH_W-1:0]   out_row_reg, out_row_next;
    logic [usm_pkg::LEAD_W-1:0] lead_reg, lead_next;
    logic [usm_pkg::LEAD_W-1:0] lead_tgt;
    logic [usm_pkg::FIFO_CNT_W-1:0] occ_reg, occ_next;

    logic                        in_acc;
    logic                        pix_go;
    logic                        drn_go;
    logic                        have;
    logic                        res0;
    logic                        last0;
    logic                        int0;
    logic [usm_pkg::FH_W-1:0]    lane_diff;
    logic [usm_pkg::LANE_W-1:0]  sel0;
    logic [usm_pkg::STORED_ROWS-1:0] mask0;
    logic [usm_pkg::COL_W-1:0]   rd_addr;
    logic                        rd_en;
    logic                        fwd0;
    logic                        pop;

    assign in_acc   = pix_in.valid && pix_in.ready;
    assign lead_tgt = usm_pkg::LEAD_W'({w_eff, 1'b0}) + usm_pkg::LEAD_W'(2);
    assign have     = (lead_reg == lead_tgt);

    // pixels beyond a complete frame and drains before it are dropped
    assign pix_go = in_acc && !pix_in.drain && (in_row_reg < h_eff);
    assign drn_go = in_acc && pix_in.drain && (in_row_reg >= h_eff) &&
                    (out_row_reg < h_eff);
    assign res0   = (pix_go && have) || drn_go;

    assign last0 = (out_row_reg == (h_eff - usm_pkg::FH_W'(1))) &&
                   (usm_pkg::WEFF_W'(out_col_reg) == (w_eff - usm_pkg::WEFF_W'(1)));

    // result lies two or more pixels from every border
    assign int0 = pix_go &&
                  (out_row_reg >= usm_pkg::FH_W'(2)) &&
                  ((17'(out_row_reg) + 17'd2) < 17'(h_eff)) &&
                  (out_col_reg >= usm_pkg::COL_W'(2)) &&
                  ((usm_pkg::WEFF_W'(out_col_reg) + usm_pkg::WEFF_W'(2)) < w_eff);

    // drain picks lane h - 1 - out_row (0..3) of the column word
    assign lane_diff = h_eff - out_row_reg - usm_pkg::FH_W'(1);
    assign sel0      = lane_diff[usm_pkg::LANE_W-1:0];

    // lane k holds row r-k, which exists only when r >= k
    always_comb
    begin
        for (int k = 0; k < usm_pkg::STORED_ROWS; k++)
        begin
            mask0[k] = (in_row_reg > usm_pkg::FH_W'(k));
        end
    end

    assign rd_en   = pix_go || drn_go;
    assign rd_addr = pix_go ? in_col_reg : out_col_reg;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lead_next    = lead_reg;
        if (pix_go)
        begin
            if ((usm_pkg::WEFF_W'(in_col_reg) + usm_pkg::WEFF_W'(1)) >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + usm_pkg::FH_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + usm_pkg::COL_W'(1);
            end
            if (!have)
                lead_next = lead_reg + usm_pkg::LEAD_W'(1);
        end
        if (res0)
        begin
            if ((usm_pkg::WEFF_W'(out_col_reg) + usm_pkg::WEFF_W'(1)) >= w_eff)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + usm_pkg::FH_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + usm_pkg::COL_W'(1);
            end
        end
        // final drain or a register write starts a fresh frame
        if ((drn_go && last0) || cfg_hit)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            lead_next    = '0;
        end
    end

    // occupancy: result beats accepted and not yet popped
    assign pop      = pix_out.valid && pix_out.ready;
    assign occ_next = occ_reg + usm_pkg::FIFO_CNT_W'(res0) - usm_pkg::FIFO_CNT_W'(pop);
    assign pix_in.ready = (occ_reg < usm_pkg::FIFO_CNT_W'(usm_pkg::FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lead_reg    <= '0;
            occ_reg     <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lead_reg    <= lead_next;
            occ_reg     <= occ_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one word per column, lane k = pixel of row r-k.
    // Read in stage 0, shifted and written back in stage 1.
    // ------------------------------------------------------------------
    logic [usm_pkg::LB_W-1:0] lb_mem [usm_pkg::MAX_WIDTH];
    logic [usm_pkg::LB_W-1:0] lb_rd_reg;
    logic [usm_pkg::LB_W-1:0] lb_word;
    logic [usm_pkg::LB_W-1:0] lb_new;
    logic                     lb_wr;

    // stage 1 control and payload
    logic                            s1_valid_reg;
    logic                            s1_res_reg;
    logic                            s1_pix_reg;
    logic                            s1_int_reg;
    logic                            s1_last_reg;
    logic [usm_pkg::LANE_W-1:0]      s1_sel_reg;
    logic [usm_pkg::STORED_ROWS-1:0] s1_mask_reg;
    usm_pkg::pix_t                   s1_px_reg;
    logic [usm_pkg::COL_W-1:0]       s1_addr_reg;
    logic                            s1_fwd_reg;
    logic [usm_pkg::LB_W-1:0]        s1_fwdw_reg;

    // back-to-back beats on one column (width 1) read before the write
    // lands: take the word being written
    assign fwd0 = lb_wr && (s1_addr_reg == rd_addr);

    always_ff @(posedge clk)
    begin
        if (lb_wr)
            lb_mem[s1_addr_reg] <= lb_new;
        if (rd_en)
            lb_rd_reg <= lb_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
            s1_res_reg   <= res0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pix_reg  <= pix_go;
        s1_int_reg  <= int0;
        s1_last_reg <= last0;
        s1_sel_reg  <= sel0;
        s1_mask_reg <= mask0;
        s1_px_reg   <= pix_in.pixel_in;
        s1_addr_reg <= rd_addr;
        s1_fwd_reg  <= fwd0;
        s1_fwdw_reg <= lb_new;
    end

    // ------------------------------------------------------------------
    // Stage 1: update column word, shift window, pick passthrough value
    // ------------------------------------------------------------------
    usm_pkg::pix_t win_reg [usm_pkg::WIN_N][usm_pkg::WIN_N];
    usm_pkg::pix_t col_new [usm_pkg::WIN_N];
    usm_pkg::pix_t pass1;

    assign lb_wr   = s1_valid_reg && s1_pix_reg;
    assign lb_word = s1_fwd_reg ? s1_fwdw_reg : lb_rd_reg;
    assign lb_new  = {lb_word[usm_pkg::LB_W-usm_pkg::PIX_W-1:0], s1_px_reg};

    always_comb
    begin
        for (int m = 0; m < usm_pkg::STORED_ROWS; m++)
        begin
            // window row m comes from lane STORED_ROWS-1-m
            if (s1_mask_reg[usm_pkg::STORED_ROWS-1-m])
                col_new[m] = lb_word[usm_pkg::PIX_W*(usm_pkg::STORED_ROWS-1-m) +:
                                     usm_pkg::PIX_W];
            else
                col_new[m] = '0;
        end
        col_new[usm_pkg::STORED_ROWS] = s1_px_reg;
    end

    // pixel beat: the result pixel is the window centre after the shift;
    // drain beat: it sits in the selected lane of the column word
    assign pass1 = s1_pix_reg ? win_reg[2][3]
                              : lb_word[usm_pkg::PIX_W*s1_sel_reg +: usm_pkg::PIX_W];

    always_ff @(posedge clk)
    begin
        if (lb_wr)
        begin
            for (int m = 0; m < usm_pkg::WIN_N; m++)
            begin
                for (int n = 0; n < usm_pkg::WIN_N - 1; n++)
                begin
                    win_reg[m][n] <= win_reg[m][n+1];
                end
                win_reg[m][usm_pkg::WIN_N-1] <= col_new[m];
            end
        end
    end

    logic          s2_res_reg;
    logic          s2_int_reg;
    logic          s2_last_reg;
    usm_pkg::pix_t s2_pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_res_reg <= 1'b0;
        else
            s2_res_reg <= s1_valid_reg && s1_res_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_int_reg  <= s1_int_reg;
        s2_last_reg <= s1_last_reg;
        s2_pass_reg <= pass1;
    end

    // ------------------------------------------------------------------
    // Stage 2: sum the window taps that share a weight
    // ------------------------------------------------------------------
    logic [usm_pkg::PIX_W+1:0] g1_2, g7_2, g16_2, g26_2;
    logic [usm_pkg::PIX_W+2:0] g4_2;

    assign g1_2  = 10'(win_reg[0][0]) + 10'(win_reg[0][4]) +
                   10'(win_reg[4][0]) + 10'(win_reg[4][4]);
    assign g4_2  = 11'(win_reg[0][1]) + 11'(win_reg[0][3]) + 11'(win_reg[1][0]) +
                   11'(win_reg[1][4]) + 11'(win_reg[3][0]) + 11'(win_reg[3][4]) +
                   11'(win_reg[4][1]) + 11'(win_reg[4][3]);
    assign g7_2  = 10'(win_reg[0][2]) + 10'(win_reg[2][0]) +
                   10'(win_reg[2][4]) + 10'(win_reg[4][2]);
    assign g16_2 = 10'(win_reg[1][1]) + 10'(win_reg[1][3]) +
                   10'(win_reg[3][1]) + 10'(win_reg[3][3]);
    assign g26_2 = 10'(win_reg[1][2]) + 10'(win_reg[2][1]) +
                   10'(win_reg[2][3]) + 10'(win_reg[3][2]);

    logic [usm_pkg::PIX_W+1:0] s3_g1_reg, s3_g7_reg, s3_g16_reg, s3_g26_reg;
    logic [usm_pkg::PIX_W+2:0] s3_g4_reg;
    usm_pkg::pix_t             s3_c_reg;
    logic                      s3_res_reg;
    logic                      s3_int_reg;
    logic                      s3_last_reg;
    usm_pkg::pix_t             s3_pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_res_reg <= 1'b0;
        else
            s3_res_reg <= s2_res_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_g1_reg   <= g1_2;
        s3_g4_reg   <= g4_2;
        s3_g7_reg   <= g7_2;
        s3_g16_reg  <= g16_2;
        s3_g26_reg  <= g26_2;
        s3_c_reg    <= win_reg[2][2];
        s3_int_reg  <= s2_int_reg;
        s3_last_reg <= s2_last_reg;
        s3_pass_reg <= s2_pass_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: weighted sum (constant weights become shift-adds)
    // ------------------------------------------------------------------
    logic [usm_pkg::SUM_W-1:0]        pos3;
    logic [usm_pkg::SUM_W-1:0]        neg3;
    logic signed [usm_pkg::SUM_W-1:0] sum3;

    assign pos3 = usm_pkg::SUM_W'(s3_c_reg) * usm_pkg::SUM_W'(usm_pkg::TAP_CENTRE);
    assign neg3 = usm_pkg::SUM_W'(s3_g1_reg)  * usm_pkg::SUM_W'(usm_pkg::TAP_A) +
                  usm_pkg::SUM_W'(s3_g4_reg)  * usm_pkg::SUM_W'(usm_pkg::TAP_B) +
                  usm_pkg::SUM_W'(s3_g7_reg)  * usm_pkg::SUM_W'(usm_pkg::TAP_C) +
                  usm_pkg::SUM_W'(s3_g16_reg) * usm_pkg::SUM_W'(usm_pkg::TAP_D) +
                  usm_pkg::SUM_W'(s3_g26_reg) * usm_pkg::SUM_W'(usm_pkg::TAP_E);
    assign sum3 = $signed(pos3 - neg3);

    logic signed [usm_pkg::SUM_W-1:0] s4_sum_reg;
    logic                             s4_res_reg;
    logic                             s4_int_reg;
    logic                             s4_last_reg;
    usm_pkg::pix_t                    s4_pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_res_reg <= 1'b0;
        else
            s4_res_reg <= s3_res_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_sum_reg  <= sum3;
        s4_int_reg  <= s3_int_reg;
        s4_last_reg <= s3_last_reg;
        s4_pass_reg <= s3_pass_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: clamp decisions and reciprocal multiply.
    // Negative sums truncate toward zero and clamp to 0; sums of 256*273
    // and above clamp to 255; everything else divides exactly.
    // ------------------------------------------------------------------
    logic                       pos4;
    logic                       sat4;
    logic [usm_pkg::PROD_W-1:0] prod4;

    assign pos4  = (s4_sum_reg > $signed(usm_pkg::SUM_W'(0)));
    assign sat4  = (s4_sum_reg >= $signed(usm_pkg::SUM_W'(usm_pkg::SAT_LIMIT)));
    assign prod4 = usm_pkg::PROD_W'(s4_sum_reg[usm_pkg::QX_W-1:0]) *
                   usm_pkg::PROD_W'(usm_pkg::RECIP);

    logic [usm_pkg::PROD_W-1:0] s5_prod_reg;
    logic                       s5_pos_reg;
    logic                       s5_sat_reg;
    logic                       s5_res_reg;
    logic                       s5_int_reg;
    logic                       s5_last_reg;
    usm_pkg::pix_t              s5_pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_res_reg <= 1'b0;
        else
            s5_res_reg <= s4_res_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_prod_reg <= prod4;
        s5_pos_reg  <= pos4;
        s5_sat_reg  <= sat4;
        s5_int_reg  <= s4_int_reg;
        s5_last_reg <= s4_last_reg;
        s5_pass_reg <= s4_pass_reg;
    end

    // ------------------------------------------------------------------
    // Stage 5: final select, push into result queue
    // ------------------------------------------------------------------
    usm_pkg::pix_t q5;
    usm_pkg::res_t res5;

    always_comb
    begin
        if (s5_sat_reg)
            q5 = '1;
        else if (!s5_pos_reg)
            q5 = '0;
        else
            q5 = s5_prod_reg[usm_pkg::RECIP_SHIFT +: usm_pkg::PIX_W];
        res5.pixel_out  = s5_int_reg ? q5 : s5_pass_reg;
        res5.frame_last = s5_last_reg;
    end

    // result queue: sized so that the occupancy check never lets it overflow
    usm_pkg::res_t                  fifo_mem [usm_pkg::FIFO_DEPTH];
    logic [usm_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [usm_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [usm_pkg::FIFO_CNT_W-1:0] cnt_reg;
    usm_pkg::res_t                  head;

    always_ff @(posedge clk)
    begin
        if (s5_res_reg)
            fifo_mem[wr_ptr_reg] <= res5;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (s5_res_reg)
                wr_ptr_reg <= wr_ptr_reg + usm_pkg::FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + usm_pkg::FIFO_PTR_W'(1);
            cnt_reg <= cnt_reg + usm_pkg::FIFO_CNT_W'(s5_res_reg) -
                       usm_pkg::FIFO_CNT_W'(pop);
        end
    end

    assign head               = fifo_mem[rd_ptr_reg];
    assign pix_out.valid      = (cnt_reg != '0);
    assign pix_out.pixel_out  = head.pixel_out;
    assign pix_out.frame_last = head.frame_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s5_res_reg |-> (cnt_reg < usm_pkg::FIFO_CNT_W'(usm_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    a_occ_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg >= cnt_reg)
        else $error("occupancy below queue fill");

    a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> $past(lb_wr))
        else $error("forwarded word without a write-back");

    a_drain_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
        drn_go |-> ((17'(out_row_reg) + 17'd4) >= 17'(h_eff)))
        else $error("drain reads a row no longer held");

endmodule
